### design/nss_pkg.sv
package nss_pkg;

    // Fixed field widths of the transactions.
    localparam int SLOT_W    = 12;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int WAYS_W    = 5;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF    = 4096;
    localparam int MAX_WAYS_DEF = 16;

    // Reset value of the ways register and the lower clamp of the ways count.
    localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(2);
    localparam int                MIN_WAYS   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WAYS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = CFG_IDX_W'(1);

    // Transaction kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // One queued transaction, already classified by the front part.
    typedef struct packed {
        logic                      is_query;
        logic                      load_ok;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    // Search sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DIV,
        ST_BRD,
        ST_BCHK,
        ST_DECIDE,
        ST_SRD,
        ST_SCHK
    } state_t;

endpackage

### design/nss_front.sv
module nss_front #(
    parameter int DEPTH = nss_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic [nss_pkg::SLOT_W-1:0]         slot,
    input  logic signed [nss_pkg::VALUE_W-1:0] value,
    input  logic                               pop,
    output logic                               item_valid,
    output nss_pkg::item_t                     item
);

    nss_pkg::item_t fifo_mem [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           do_pop;
    nss_pkg::item_t new_item;

    // Classify the incoming transaction.
    always_comb
    begin
        new_item.is_query = (kind == nss_pkg::KIND_QUERY);
        new_item.load_ok  = (32'(slot) < 32'(DEPTH));
        new_item.slot     = slot;
        new_item.value    = value;
    end

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign item_valid = (count_reg != 2'd0);
    assign do_pop     = pop && item_valid;
    assign item       = fifo_mem[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### design/nss_engine.sv
module nss_engine #(
    parameter int DEPTH    = nss_pkg::DEPTH_DEF,
    parameter int MAX_WAYS = nss_pkg::MAX_WAYS_DEF,
    parameter int W        = ($clog2(DEPTH) + 2 > 15) ? $clog2(DEPTH) + 2 : 15,
    parameter int NW       = $clog2(MAX_WAYS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  nss_pkg::item_t             item,
    output logic                       pop,
    input  logic [NW-1:0]              n_eff,
    input  logic [W-1:0]               len_eff,
    output logic                       done,
    output logic                       found,
    output logic [nss_pkg::SLOT_W-1:0] position
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(W + 1);

    nss_pkg::state_t state_reg;
    nss_pkg::state_t state_next;

    logic signed [nss_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [nss_pkg::VALUE_W-1:0] mem_q_reg;
    logic                               rd_en;
    logic [W-1:0]                       rd_idx;

    logic signed [nss_pkg::VALUE_W-1:0] target_reg;
    logic signed [nss_pkg::VALUE_W-1:0] prev_reg;
    logic signed [W-1:0] low_reg;
    logic signed [W-1:0] high_reg;
    logic [W-1:0]        idx_reg;
    logic [W-1:0]        b1_reg;
    logic [W-1:0]        prevb_reg;
    logic [W-1:0]        plow_reg;
    logic [W-1:0]        phigh_reg;
    logic [W-1:0]        dq_reg;
    logic [NW:0]         rem_reg;
    logic [CW-1:0]       cnt_reg;
    logic [W-1:0]        qstep_reg;
    logic [NW-1:0]       rstep_reg;
    logic [W-1:0]        qacc_reg;
    logic [NW-1:0]       racc_reg;
    logic [NW-1:0]       way_reg;
    logic                first_lt_reg;
    logic                last_gt_reg;
    logic                pair_reg;
    logic                done_reg;
    logic                found_reg;
    logic [nss_pkg::SLOT_W-1:0] position_reg;

    logic [W-1:0]  span;
    logic          range_empty;
    logic          do_scan;
    logic [NW:0]   rem_sh;
    logic          div_ge;
    logic [NW:0]   rem_nx;
    logic [W-1:0]  dq_nx;
    logic [NW:0]   rsum;
    logic          wrap;
    logic [NW:0]   rsum_adj;
    logic [W-1:0]  bnd;
    logic          hit;
    logic          t_lt;
    logic          t_gt;
    logic          last_way;

    // Range tests for the current round.
    assign span        = W'(high_reg - low_reg);
    assign range_empty = (low_reg > high_reg);
    assign do_scan     = (span < W'(n_eff));

    // One restoring division step of span by the number of ways.
    assign rem_sh = {rem_reg[NW-1:0], dq_reg[W-1]};
    assign div_ge = (rem_sh >= {1'b0, n_eff});
    assign rem_nx = div_ge ? (rem_sh - {1'b0, n_eff}) : rem_sh;
    assign dq_nx  = {dq_reg[W-2:0], div_ge};

    // Step from boundary i to i+1: add the quotient and carry the remainder.
    assign rsum     = {1'b0, racc_reg} + {1'b0, rstep_reg};
    assign wrap     = (rsum >= {1'b0, n_eff});
    assign rsum_adj = wrap ? (rsum - {1'b0, n_eff}) : rsum;
    assign bnd      = W'(low_reg) + qacc_reg;

    // Compare of the entry just read against the target.
    assign hit      = (mem_q_reg == target_reg);
    assign t_lt     = (target_reg < mem_q_reg);
    assign t_gt     = (target_reg > mem_q_reg);
    assign last_way = (way_reg == (n_eff - NW'(1)));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nss_pkg::ST_IDLE:
            begin
                if (item_valid && item.is_query)
                begin
                    state_next = nss_pkg::ST_ROUND;
                end
            end
            nss_pkg::ST_ROUND:
            begin
                priority if (range_empty)
                begin
                    state_next = nss_pkg::ST_IDLE;
                end
                else if (do_scan)
                begin
                    state_next = nss_pkg::ST_SRD;
                end
                else
                begin
                    state_next = nss_pkg::ST_DIV;
                end
            end
            nss_pkg::ST_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = nss_pkg::ST_BRD;
                end
            end
            nss_pkg::ST_BRD:
            begin
                state_next = nss_pkg::ST_BCHK;
            end
            nss_pkg::ST_BCHK:
            begin
                priority if (hit)
                begin
                    state_next = nss_pkg::ST_IDLE;
                end
                else if (last_way)
                begin
                    state_next = nss_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = nss_pkg::ST_BRD;
                end
            end
            nss_pkg::ST_DECIDE:
            begin
                if (first_lt_reg || last_gt_reg || pair_reg)
                begin
                    state_next = nss_pkg::ST_ROUND;
                end
                else
                begin
                    state_next = nss_pkg::ST_IDLE;
                end
            end
            nss_pkg::ST_SRD:
            begin
                state_next = nss_pkg::ST_SCHK;
            end
            nss_pkg::ST_SCHK:
            begin
                if (hit || (idx_reg == W'(high_reg)))
                begin
                    state_next = nss_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = nss_pkg::ST_SRD;
                end
            end
            default:
            begin
                state_next = nss_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: queue pop and memory read port.
    always_comb
    begin
        pop    = 1'b0;
        rd_en  = 1'b0;
        rd_idx = idx_reg;
        unique case (state_reg)
            nss_pkg::ST_IDLE:
            begin
                pop = item_valid;
            end
            nss_pkg::ST_BRD:
            begin
                rd_en  = 1'b1;
                rd_idx = bnd;
            end
            nss_pkg::ST_SRD:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nss_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                nss_pkg::ST_ROUND:
                begin
                    done_reg <= range_empty;
                end
                nss_pkg::ST_BCHK:
                begin
                    done_reg <= hit;
                end
                nss_pkg::ST_DECIDE:
                begin
                    done_reg <= !(first_lt_reg || last_gt_reg || pair_reg);
                end
                nss_pkg::ST_SCHK:
                begin
                    done_reg <= hit || (idx_reg == W'(high_reg));
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    // Search datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            nss_pkg::ST_IDLE:
            begin
                target_reg <= item.value;
                low_reg    <= '0;
                high_reg   <= $signed(len_eff) - W'(1);
            end
            nss_pkg::ST_ROUND:
            begin
                idx_reg   <= W'(low_reg);
                dq_reg    <= span;
                rem_reg   <= '0;
                cnt_reg   <= CW'(W);
                pair_reg  <= 1'b0;
                if (range_empty)
                begin
                    found_reg    <= 1'b0;
                    position_reg <= '0;
                end
            end
            nss_pkg::ST_DIV:
            begin
                dq_reg  <= dq_nx;
                rem_reg <= rem_nx;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    qstep_reg <= dq_nx;
                    rstep_reg <= rem_nx[NW-1:0];
                    qacc_reg  <= dq_nx;
                    racc_reg  <= rem_nx[NW-1:0];
                    way_reg   <= NW'(1);
                end
            end
            nss_pkg::ST_BRD:
            begin
                idx_reg <= bnd;
            end
            nss_pkg::ST_BCHK:
            begin
                found_reg    <= 1'b1;
                position_reg <= idx_reg[nss_pkg::SLOT_W-1:0];
                if (way_reg == NW'(1))
                begin
                    first_lt_reg <= t_lt;
                    b1_reg       <= idx_reg;
                end
                else if (!pair_reg && (target_reg > prev_reg) && t_lt)
                begin
                    pair_reg  <= 1'b1;
                    plow_reg  <= prevb_reg + W'(1);
                    phigh_reg <= idx_reg - W'(1);
                end
                last_gt_reg <= t_gt;
                prev_reg    <= mem_q_reg;
                prevb_reg   <= idx_reg;
                way_reg     <= way_reg + NW'(1);
                qacc_reg    <= qacc_reg + qstep_reg + W'(wrap);
                racc_reg    <= rsum_adj[NW-1:0];
            end
            nss_pkg::ST_DECIDE:
            begin
                found_reg    <= 1'b0;
                position_reg <= '0;
                priority if (first_lt_reg)
                begin
                    high_reg <= $signed(b1_reg - W'(1));
                end
                else if (last_gt_reg)
                begin
                    low_reg <= $signed(idx_reg + W'(1));
                end
                else if (pair_reg)
                begin
                    low_reg  <= $signed(plow_reg);
                    high_reg <= $signed(phigh_reg);
                end
                else
                begin
                    low_reg <= low_reg;
                end
            end
            nss_pkg::ST_SCHK:
            begin
                found_reg    <= hit;
                position_reg <= hit ? idx_reg[nss_pkg::SLOT_W-1:0] : '0;
                idx_reg      <= idx_reg + W'(1);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Table storage: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if ((state_reg == nss_pkg::ST_IDLE) && item_valid && !item.is_query
            && item.load_ok)
        begin
            mem[AW'(item.slot)] <= item.value;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

### design/nary_sorted_search.sv
// Loads write the table from the engine's idle state; a query runs in rounds
// through the bit-serial boundary divider and the single read port of the
// table and may end in a linear scan. W, the index width, is 15 at the default
// depth. Transactions pass through a two-entry queue.
// The result strobe done is high for one cycle; the receiver cannot stall.
// Reset clears control state and the configuration registers; the table is undefined until loaded.
module nary_sorted_search #(
    parameter int DEPTH    = nss_pkg::DEPTH_DEF,
    parameter int MAX_WAYS = nss_pkg::MAX_WAYS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [nss_pkg::SLOT_W-1:0]           slot,
    input  logic signed [nss_pkg::VALUE_W-1:0]   value,
    output logic                                 done,
    output logic                                 found,
    output logic [nss_pkg::SLOT_W-1:0]           position,
    input  logic                                 cfg_we,
    input  logic [nss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nss_pkg::CFG_W-1:0]            cfg_data
);

    localparam int W  = ($clog2(DEPTH) + 2 > 15) ? $clog2(DEPTH) + 2 : 15;
    localparam int NW = $clog2(MAX_WAYS + 1);

    logic [nss_pkg::WAYS_W-1:0] ways_reg;
    logic [nss_pkg::CFG_W-1:0]  length_reg;
    logic [NW-1:0]              n_eff;
    logic [W-1:0]               len_eff;
    logic                       item_valid;
    logic                       pop;
    nss_pkg::item_t             item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg   <= nss_pkg::WAYS_RESET;
            length_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == nss_pkg::REG_WAYS)
            begin
                ways_reg <= cfg_data[nss_pkg::WAYS_W-1:0];
            end
            else if (cfg_index == nss_pkg::REG_LENGTH)
            begin
                length_reg <= cfg_data;
            end
        end
    end

    // Clamp the ways count and the searched length to what the hardware holds.
    always_comb
    begin
        priority if (32'(ways_reg) < 32'(nss_pkg::MIN_WAYS))
        begin
            n_eff = NW'(nss_pkg::MIN_WAYS);
        end
        else if (32'(ways_reg) > 32'(MAX_WAYS))
        begin
            n_eff = NW'(MAX_WAYS);
        end
        else
        begin
            n_eff = NW'(ways_reg);
        end
        len_eff = (32'(length_reg) > 32'(DEPTH)) ? W'(DEPTH) : W'(length_reg);
    end

    nss_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .slot       (slot),
        .value      (value),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    nss_engine #(
        .DEPTH    (DEPTH),
        .MAX_WAYS (MAX_WAYS),
        .W        (W),
        .NW       (NW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .n_eff      (n_eff),
        .len_eff    (len_eff),
        .done       (done),
        .found      (found),
        .position   (position)
    );

endmodule
